/* rtl/jpar_pkg.sv */
// Package for the joypad edge and auto-repeat block.
// Holds field widths, reset values, register index codes and the word types.
// Used by jpar_pad, jpar_panel and joypad_edge_and_auto_repeat.
package jpar_pkg;

    localparam int PAD_W       = 8;
    localparam int PANEL_W     = 4;
    localparam int COUNT_W     = 5;
    localparam int CFG_INDEX_W = 2;

    localparam logic [PANEL_W-1:0] START_MASK     = 4'h5;
    localparam logic [COUNT_W-1:0] DELAY_RESET    = 5'd16;
    localparam logic [COUNT_W-1:0] INTERVAL_RESET = 5'd8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REPEAT_DELAY    = 2'd0,
        CFG_REPEAT_INTERVAL = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [PAD_W-1:0]   pad1_port;
        logic [PAD_W-1:0]   pad2_port;
        logic [PANEL_W-1:0] start_select_port;
    } in_word_t;

    typedef struct packed {
        logic [PAD_W-1:0] now;
        logic [PAD_W-1:0] prev;
        logic [PAD_W-1:0] pressed;
        logic [PAD_W-1:0] rep;
    } pad_result_t;

    typedef struct packed {
        logic [PANEL_W-1:0] now_raw;
        logic [PANEL_W-1:0] rise_raw;
        logic [PANEL_W-1:0] starts_now;
        logic [PANEL_W-1:0] starts_rise;
    } panel_result_t;

endpackage

/* rtl/jpar_pad.sv */
// One joypad channel: inversion, edge detection and the auto-repeat countdown.
// Depends on jpar_pkg for widths and the pad_result_t type.
// State advances only on a step, one frame word at a time.
module jpar_pad (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step,
    input  logic [jpar_pkg::PAD_W-1:0]       port,
    input  logic [jpar_pkg::COUNT_W-1:0]     repeat_delay,
    input  logic [jpar_pkg::COUNT_W-1:0]     repeat_interval,
    output jpar_pkg::pad_result_t            result
);

    logic [jpar_pkg::PAD_W-1:0]   now;
    logic [jpar_pkg::PAD_W-1:0]   held_reg;
    logic [jpar_pkg::PAD_W-1:0]   held_next;
    logic [jpar_pkg::COUNT_W-1:0] countdown_reg;
    logic [jpar_pkg::COUNT_W-1:0] countdown_next;
    logic [jpar_pkg::PAD_W-1:0]   latched_reg;
    logic [jpar_pkg::PAD_W-1:0]   latched_next;

    assign now = ~port;

    always_comb begin
        held_next      = held_reg;
        countdown_next = countdown_reg;
        latched_next   = latched_reg;
        if (step) begin
            held_next = now;
            priority if (now != held_reg) begin
                countdown_next = repeat_delay;
                latched_next   = now;
            end else if (countdown_reg == '0) begin
                countdown_next = repeat_interval;
                latched_next   = now;
            end else begin
                countdown_next = countdown_reg - jpar_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= '0;
            countdown_reg <= '0;
            latched_reg   <= '0;
        end else begin
            held_reg      <= held_next;
            countdown_reg <= countdown_next;
            latched_reg   <= latched_next;
        end
    end

    assign result.now     = now;
    assign result.prev    = held_reg;
    assign result.pressed = now & ~held_reg;
    assign result.rep     = latched_next;

    // A changed frame reloads the delay and latches the new buttons.
    a_change_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (now != held_reg)) |=>
        (countdown_reg == $past(repeat_delay)) && (latched_reg == $past(now)))
        else $error("pad countdown not reloaded with delay on change");

    // An unchanged frame at zero reloads the interval and refreshes the latch.
    a_underflow_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (now == held_reg) && (countdown_reg == '0)) |=>
        (countdown_reg == $past(repeat_interval)) && (latched_reg == $past(now)))
        else $error("pad countdown not reloaded with interval on underflow");

    // An unchanged frame with time left counts down and keeps the latch.
    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (now == held_reg) && (countdown_reg != '0)) |=>
        (countdown_reg == $past(countdown_reg) - jpar_pkg::COUNT_W'(1)) &&
        $stable(latched_reg))
        else $error("pad countdown did not decrement while held");

endmodule

/* rtl/jpar_panel.sv */
// Start/select panel nibble: inversion, rising edges and start-bit masking.
// Depends on jpar_pkg for widths, START_MASK and the panel_result_t type.
module jpar_panel (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  logic [jpar_pkg::PANEL_W-1:0]   port,
    output jpar_pkg::panel_result_t        result
);

    logic [jpar_pkg::PANEL_W-1:0] now;
    logic [jpar_pkg::PANEL_W-1:0] rise;
    logic [jpar_pkg::PANEL_W-1:0] held_reg;
    logic [jpar_pkg::PANEL_W-1:0] held_next;

    assign now       = ~port;
    assign rise      = now & ~held_reg;
    assign held_next = step ? now : held_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else begin
            held_reg <= held_next;
        end
    end

    assign result.now_raw     = now;
    assign result.rise_raw    = rise;
    assign result.starts_now  = now & jpar_pkg::START_MASK;
    assign result.starts_rise = rise & jpar_pkg::START_MASK;

endmodule

/* rtl/joypad_edge_and_auto_repeat.sv */
// Top level of the joypad edge and auto-repeat block.
// Instantiates jpar_pad twice and jpar_panel; uses jpar_pkg types and codes.
//
// Channel | Direction | Handshake           | Word
// s_      | in        | s_valid / s_ready   | pad1, pad2 ports, start/select nibble
// m_      | out       | m_valid / m_ready   | per-pad now/before/pressed/repeat, panel
// cfg_    | in        | cfg_valid/cfg_ready | register index and write data
//
// Each word passes through the input register and then moves into the result register,
// and one word is accepted every cycle while the result side does not stall.
// The result register stalls on m_ready; the input register fills behind it and
// s_ready drops only when both hold a word and m_ready is low.
// Reset clears the pad and panel history, the countdowns and the latched repeat
// bytes, and loads the delay with 16 and the interval with 8. cfg_ready is always high.
module joypad_edge_and_auto_repeat (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [jpar_pkg::PAD_W-1:0]          s_pad1_port,
    input  logic [jpar_pkg::PAD_W-1:0]          s_pad2_port,
    input  logic [jpar_pkg::PANEL_W-1:0]        s_start_select_port,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [jpar_pkg::PAD_W-1:0]          m_pad1_now,
    output logic [jpar_pkg::PAD_W-1:0]          m_pad1_before,
    output logic [jpar_pkg::PAD_W-1:0]          m_pad1_pressed,
    output logic [jpar_pkg::PAD_W-1:0]          m_pad1_repeat,
    output logic [jpar_pkg::PAD_W-1:0]          m_pad2_now,
    output logic [jpar_pkg::PAD_W-1:0]          m_pad2_before,
    output logic [jpar_pkg::PAD_W-1:0]          m_pad2_pressed,
    output logic [jpar_pkg::PAD_W-1:0]          m_pad2_repeat,
    output logic [jpar_pkg::PANEL_W-1:0]        m_panel_now_raw,
    output logic [jpar_pkg::PANEL_W-1:0]        m_panel_rise_raw,
    output logic [jpar_pkg::PANEL_W-1:0]        m_starts_now,
    output logic [jpar_pkg::PANEL_W-1:0]        m_starts_rise,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jpar_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [jpar_pkg::COUNT_W-1:0]        cfg_data
);

    logic                         in_valid_reg;
    logic                         in_valid_next;
    jpar_pkg::in_word_t           in_word_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    jpar_pkg::pad_result_t        pad1_out_reg;
    jpar_pkg::pad_result_t        pad2_out_reg;
    jpar_pkg::panel_result_t      panel_out_reg;
    logic [jpar_pkg::COUNT_W-1:0] delay_reg;
    logic [jpar_pkg::COUNT_W-1:0] delay_next;
    logic [jpar_pkg::COUNT_W-1:0] interval_reg;
    logic [jpar_pkg::COUNT_W-1:0] interval_next;

    logic                         out_free;
    logic                         step;
    logic                         s_take;
    jpar_pkg::pad_result_t        pad1_result;
    jpar_pkg::pad_result_t        pad2_result;
    jpar_pkg::panel_result_t      panel_result;

    assign out_free  = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_take || (in_valid_reg && !out_free);
    assign out_valid_next = step || (out_valid_reg && !m_ready);

    always_comb begin
        delay_next    = delay_reg;
        interval_next = interval_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                jpar_pkg::CFG_REPEAT_DELAY:    delay_next    = cfg_data;
                jpar_pkg::CFG_REPEAT_INTERVAL: interval_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            delay_reg     <= jpar_pkg::DELAY_RESET;
            interval_reg  <= jpar_pkg::INTERVAL_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            delay_reg     <= delay_next;
            interval_reg  <= interval_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_word_reg.pad1_port         <= s_pad1_port;
            in_word_reg.pad2_port         <= s_pad2_port;
            in_word_reg.start_select_port <= s_start_select_port;
        end
        if (step) begin
            pad1_out_reg  <= pad1_result;
            pad2_out_reg  <= pad2_result;
            panel_out_reg <= panel_result;
        end
    end

    jpar_pad u_pad1 (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (step),
        .port            (in_word_reg.pad1_port),
        .repeat_delay    (delay_reg),
        .repeat_interval (interval_reg),
        .result          (pad1_result)
    );

    jpar_pad u_pad2 (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (step),
        .port            (in_word_reg.pad2_port),
        .repeat_delay    (delay_reg),
        .repeat_interval (interval_reg),
        .result          (pad2_result)
    );

    jpar_panel u_panel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .port    (in_word_reg.start_select_port),
        .result  (panel_result)
    );

    assign m_valid          = out_valid_reg;
    assign m_pad1_now       = pad1_out_reg.now;
    assign m_pad1_before    = pad1_out_reg.prev;
    assign m_pad1_pressed   = pad1_out_reg.pressed;
    assign m_pad1_repeat    = pad1_out_reg.rep;
    assign m_pad2_now       = pad2_out_reg.now;
    assign m_pad2_before    = pad2_out_reg.prev;
    assign m_pad2_pressed   = pad2_out_reg.pressed;
    assign m_pad2_repeat    = pad2_out_reg.rep;
    assign m_panel_now_raw  = panel_out_reg.now_raw;
    assign m_panel_rise_raw = panel_out_reg.rise_raw;
    assign m_starts_now     = panel_out_reg.starts_now;
    assign m_starts_rise    = panel_out_reg.starts_rise;

    // With both registers full and the result stalled, no new word may enter.
    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while both stages are full and stalled");

    // A word leaving the input register always lands in the result register.
    a_step_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid)
        else $error("processed word did not reach the result register");

    // A stalled word in the input register stays there until it can move.
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> in_valid_reg && $stable(in_word_reg))
        else $error("input word lost while the result side stalled");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for joypad_edge_and_auto_repeat: directed frames, then random
// held-button sequences under several repeat settings, with random gaps and stalls.
// Depends on jpar_pkg and the joypad_edge_and_auto_repeat top level only.
module tb;

    localparam logic [jpar_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [jpar_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int PIPE_CYCLES = 2;
    localparam int PHASES = 10;
    localparam int PHASE_WORDS = 104;

    typedef struct packed {
        jpar_pkg::pad_result_t   p1;
        jpar_pkg::pad_result_t   p2;
        jpar_pkg::panel_result_t panel;
    } frame_result_t;

    typedef struct packed {
        logic [jpar_pkg::PAD_W-1:0]   held;
        logic [jpar_pkg::COUNT_W-1:0] count;
        logic [jpar_pkg::PAD_W-1:0]   latched;
    } pad_track_t;

    typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        jpar_pkg::in_word_t               word;
        logic [jpar_pkg::CFG_INDEX_W-1:0] index;
        logic [jpar_pkg::COUNT_W-1:0]     data;
        bit                               typed;
        frame_result_t                    result;
    } plan_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [jpar_pkg::PAD_W-1:0] s_pad1_port;
    logic [jpar_pkg::PAD_W-1:0] s_pad2_port;
    logic [jpar_pkg::PANEL_W-1:0] s_start_select_port;
    logic m_valid;
    logic m_ready;
    logic [jpar_pkg::PAD_W-1:0] m_pad1_now, m_pad1_before, m_pad1_pressed, m_pad1_repeat;
    logic [jpar_pkg::PAD_W-1:0] m_pad2_now, m_pad2_before, m_pad2_pressed, m_pad2_repeat;
    logic [jpar_pkg::PANEL_W-1:0] m_panel_now_raw, m_panel_rise_raw;
    logic [jpar_pkg::PANEL_W-1:0] m_starts_now, m_starts_rise;
    logic cfg_valid;
    logic cfg_ready;
    logic [jpar_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [jpar_pkg::COUNT_W-1:0] cfg_data;

    logic [jpar_pkg::COUNT_W-1:0] delay_cfg;
    logic [jpar_pkg::COUNT_W-1:0] interval_cfg;
    pad_track_t pad1_track;
    pad_track_t pad2_track;
    logic [jpar_pkg::PANEL_W-1:0] panel_held;
    frame_result_t pending_frames [$];
    plan_row_t directed_plan [$];
    int mismatches = 0;
    bit steady = 1'b0;

    joypad_edge_and_auto_repeat dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_pad1_port         (s_pad1_port),
        .s_pad2_port         (s_pad2_port),
        .s_start_select_port (s_start_select_port),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_pad1_now          (m_pad1_now),
        .m_pad1_before       (m_pad1_before),
        .m_pad1_pressed      (m_pad1_pressed),
        .m_pad1_repeat       (m_pad1_repeat),
        .m_pad2_now          (m_pad2_now),
        .m_pad2_before       (m_pad2_before),
        .m_pad2_pressed      (m_pad2_pressed),
        .m_pad2_repeat       (m_pad2_repeat),
        .m_panel_now_raw     (m_panel_now_raw),
        .m_panel_rise_raw    (m_panel_rise_raw),
        .m_starts_now        (m_starts_now),
        .m_starts_rise       (m_starts_rise),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic jpar_pkg::pad_result_t advance_pad(
        inout pad_track_t t, input logic [jpar_pkg::PAD_W-1:0] port);
        jpar_pkg::pad_result_t r;
        r.now = ~port;
        r.prev = t.held;
        if (r.now == r.prev) begin
            if (t.count == '0) begin
                t.count = interval_cfg;
                t.latched = r.now;
            end else begin
                t.count = t.count - jpar_pkg::COUNT_W'(1);
            end
        end else begin
            t.count = delay_cfg;
            t.latched = r.now;
        end
        t.held = r.now;
        r.pressed = r.now & ~r.prev;
        r.rep = t.latched;
        return r;
    endfunction

    function automatic frame_result_t predict_frame(input jpar_pkg::in_word_t w);
        frame_result_t r;
        r.p1 = advance_pad(pad1_track, w.pad1_port);
        r.p2 = advance_pad(pad2_track, w.pad2_port);
        r.panel.now_raw = ~w.start_select_port;
        r.panel.rise_raw = r.panel.now_raw & ~panel_held;
        r.panel.starts_now = r.panel.now_raw & jpar_pkg::START_MASK;
        r.panel.starts_rise = r.panel.rise_raw & jpar_pkg::START_MASK;
        panel_held = r.panel.now_raw;
        return r;
    endfunction

    function automatic plan_row_t word_row(input logic [jpar_pkg::PAD_W-1:0] p1,
                                           input logic [jpar_pkg::PAD_W-1:0] p2,
                                           input logic [jpar_pkg::PANEL_W-1:0] ss);
        plan_row_t row;
        row.kind = ROW_WORD;
        row.word = {p1, p2, ss};
        row.index = jpar_pkg::CFG_REPEAT_DELAY;
        row.data = '0;
        row.typed = 1'b0;
        row.result = '0;
        return row;
    endfunction

    function automatic plan_row_t typed_row(input logic [jpar_pkg::PAD_W-1:0] p1,
                                            input logic [jpar_pkg::PAD_W-1:0] p2,
                                            input logic [jpar_pkg::PANEL_W-1:0] ss,
                                            input frame_result_t r);
        plan_row_t row;
        row = word_row(p1, p2, ss);
        row.typed = 1'b1;
        row.result = r;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [jpar_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [jpar_pkg::COUNT_W-1:0] data);
        plan_row_t row;
        row = word_row('0, '0, '0);
        row.kind = ROW_CFG;
        row.index = idx;
        row.data = data;
        return row;
    endfunction

    task automatic send_word(input jpar_pkg::in_word_t w, input bit typed,
                             input frame_result_t typed_result);
        frame_result_t r;
        while (!steady && $urandom_range(0, 99) < 34) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pad1_port <= w.pad1_port;
        s_pad2_port <= w.pad2_port;
        s_start_select_port <= w.start_select_port;
        do @(posedge aclk); while (!s_ready);
        r = predict_frame(w);
        pending_frames.push_back(typed ? typed_result : r);
    endtask

    task automatic write_register(input logic [jpar_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [jpar_pkg::COUNT_W-1:0] data);
        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (PIPE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            jpar_pkg::CFG_REPEAT_DELAY:    delay_cfg = data;
            jpar_pkg::CFG_REPEAT_INTERVAL: interval_cfg = data;
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [jpar_pkg::PAD_W-1:0] want,
                               input logic [jpar_pkg::PAD_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected %h, got %h", name, want, got);
            end
        end
    endtask

    function automatic logic [jpar_pkg::PAD_W-1:0] pick_pad(
        input logic [jpar_pkg::PAD_W-1:0] cur);
        case ($urandom_range(0, 7))
            0: return 8'hFF;
            1: return 8'h00;
            2, 3: return cur ^ (8'h01 << $urandom_range(0, 7));
            default: return jpar_pkg::PAD_W'($urandom);
        endcase
    endfunction

    function automatic int pick_hold();
        return $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 70);
    endfunction

    initial begin
        frame_result_t want;
        frame_result_t got;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = {m_pad1_now, m_pad1_before, m_pad1_pressed, m_pad1_repeat,
                       m_pad2_now, m_pad2_before, m_pad2_pressed, m_pad2_repeat,
                       m_panel_now_raw, m_panel_rise_raw, m_starts_now, m_starts_rise};
                if (pending_frames.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result word with nothing pending: %h", got);
                    end
                end else begin
                    want = pending_frames.pop_front();
                    check_field("pad1_now", want.p1.now, got.p1.now);
                    check_field("pad1_before", want.p1.prev, got.p1.prev);
                    check_field("pad1_pressed", want.p1.pressed, got.p1.pressed);
                    check_field("pad1_repeat", want.p1.rep, got.p1.rep);
                    check_field("pad2_now", want.p2.now, got.p2.now);
                    check_field("pad2_before", want.p2.prev, got.p2.prev);
                    check_field("pad2_pressed", want.p2.pressed, got.p2.pressed);
                    check_field("pad2_repeat", want.p2.rep, got.p2.rep);
                    check_field("panel_now_raw", jpar_pkg::PAD_W'(want.panel.now_raw),
                                jpar_pkg::PAD_W'(got.panel.now_raw));
                    check_field("panel_rise_raw", jpar_pkg::PAD_W'(want.panel.rise_raw),
                                jpar_pkg::PAD_W'(got.panel.rise_raw));
                    check_field("starts_now", jpar_pkg::PAD_W'(want.panel.starts_now),
                                jpar_pkg::PAD_W'(got.panel.starts_now));
                    check_field("starts_rise", jpar_pkg::PAD_W'(want.panel.starts_rise),
                                jpar_pkg::PAD_W'(got.panel.starts_rise));
                end
            end
            m_ready <= (steady || $urandom_range(0, 99) >= 34);
        end
    end

    initial begin
        logic [jpar_pkg::COUNT_W-1:0] fixed_delay [5];
        logic [jpar_pkg::COUNT_W-1:0] fixed_interval [5];
        logic [jpar_pkg::PAD_W-1:0] cur1;
        logic [jpar_pkg::PAD_W-1:0] cur2;
        logic [jpar_pkg::PANEL_W-1:0] curp;
        int hold1;
        int hold2;
        int holdp;
        fixed_delay = '{5'd31, 5'd0, 5'd1, 5'd0, 5'd31};
        fixed_interval = '{5'd31, 5'd0, 5'd0, 5'd31, 5'd1};
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_pad1_port <= '1;
        s_pad2_port <= '1;
        s_start_select_port <= '1;
        cfg_valid <= 1'b0;
        cfg_index <= jpar_pkg::CFG_REPEAT_DELAY;
        cfg_data <= '0;
        delay_cfg = jpar_pkg::DELAY_RESET;
        interval_cfg = jpar_pkg::INTERVAL_RESET;
        pad1_track = '0;
        pad2_track = '0;
        panel_held = '0;
        cur1 = '1;
        cur2 = '1;
        curp = '1;
        hold1 = 0;
        hold2 = 0;
        holdp = 0;

        directed_plan.push_back(typed_row(8'hFF, 8'hFF, 4'hF, '0));
        directed_plan.push_back(typed_row(8'h00, 8'h00, 4'h0,
            {8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 4'hF, 4'hF, 4'h5, 4'h5}));
        directed_plan.push_back(typed_row(8'h00, 8'h00, 4'h0,
            {8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 4'hF, 4'h0, 4'h5, 4'h0}));
        directed_plan.push_back(word_row(8'hFE, 8'h7F, 4'hE));
        directed_plan.push_back(word_row(8'h55, 8'hAA, 4'h5));
        directed_plan.push_back(word_row(8'hAA, 8'h55, 4'hA));
        directed_plan.push_back(word_row(8'hFF, 8'h00, 4'hF));
        directed_plan.push_back(cfg_row(jpar_pkg::CFG_REPEAT_DELAY, 5'd0));
        directed_plan.push_back(cfg_row(jpar_pkg::CFG_REPEAT_INTERVAL, 5'd0));
        directed_plan.push_back(word_row(8'h0F, 8'hF0, 4'h3));
        directed_plan.push_back(word_row(8'h0F, 8'hF0, 4'h3));
        directed_plan.push_back(word_row(8'h0F, 8'hF0, 4'h3));
        directed_plan.push_back(cfg_row(CFG_SPARE_A, 5'd31));
        directed_plan.push_back(cfg_row(CFG_SPARE_B, 5'd31));
        directed_plan.push_back(cfg_row(jpar_pkg::CFG_REPEAT_DELAY, 5'd1));
        directed_plan.push_back(cfg_row(jpar_pkg::CFG_REPEAT_INTERVAL, 5'd31));
        directed_plan.push_back(word_row(8'h3C, 8'hC3, 4'hC));
        directed_plan.push_back(word_row(8'h3C, 8'hC3, 4'hC));
        directed_plan.push_back(word_row(8'h3C, 8'hC3, 4'hC));
        directed_plan.push_back(word_row(8'h3C, 8'hC3, 4'hC));
        directed_plan.push_back(cfg_row(jpar_pkg::CFG_REPEAT_DELAY, 5'd31));
        directed_plan.push_back(word_row(8'h81, 8'h18, 4'h9));
        directed_plan.push_back(word_row(8'h7E, 8'hE7, 4'h6));
        directed_plan.push_back(word_row(8'hFF, 8'hFF, 4'hF));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_CFG) begin
                write_register(directed_plan[i].index, directed_plan[i].data);
            end else begin
                send_word(directed_plan[i].word, directed_plan[i].typed,
                          directed_plan[i].result);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            write_register(jpar_pkg::CFG_REPEAT_DELAY,
                           ph < 5 ? fixed_delay[ph]
                                  : jpar_pkg::COUNT_W'($urandom_range(0, 31)));
            if ($urandom_range(0, 3) == 0) begin
                write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                               jpar_pkg::COUNT_W'($urandom));
            end
            write_register(jpar_pkg::CFG_REPEAT_INTERVAL,
                           ph < 5 ? fixed_interval[ph]
                                  : jpar_pkg::COUNT_W'($urandom_range(0, 31)));
            steady = (ph == 4);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (hold1 == 0) begin
                    cur1 = pick_pad(cur1);
                    hold1 = pick_hold();
                end else begin
                    hold1--;
                end
                if (hold2 == 0) begin
                    cur2 = pick_pad(cur2);
                    hold2 = pick_hold();
                end else begin
                    hold2--;
                end
                if (holdp == 0) begin
                    curp = jpar_pkg::PANEL_W'($urandom_range(0, 15));
                    holdp = $urandom_range(0, 6);
                end else begin
                    holdp--;
                end
                send_word({cur1, cur2, curp}, 1'b0, '0);
            end
            steady = 1'b0;
        end

        s_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("joypad_edge_and_auto_repeat: match");
        end else begin
            $display("joypad_edge_and_auto_repeat: mismatch");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("joypad_edge_and_auto_repeat: mismatch");
        $finish;
    end

endmodule
